@@ rtl/core/qmsn_pkg.sv @@
// Shared widths, stage counts and transaction types for the quaternion normaliser.
package qmsn_pkg;

  localparam int COMP_W      = 32;  // Q2.29 component
  localparam int TERM_W      = 35;  // one floored partial product, Q5.29
  localparam int P_W         = 37;  // summed product component, Q7.29
  localparam int MAG_W       = 36;  // magnitude of a product component
  localparam int LEN_W       = 6;   // bit length of the largest magnitude
  localparam int SQ_W        = 61;  // square of one scaled component
  localparam int N_W         = 64;  // squared norm and root working width
  localparam int S_W         = 32;  // integer square root of the norm
  localparam int SQRT_STAGES = 32;
  localparam int REM_W       = 33;
  localparam int R_W         = 34;  // reciprocal floor(2^62 / s)
  localparam int DIV_STAGES  = 34;
  localparam int MUL_W       = 67;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  // Raw product handed from the front end to the normaliser.
  typedef struct packed {
    logic signed [P_W-1:0] w;
    logic signed [P_W-1:0] x;
    logic signed [P_W-1:0] y;
    logic signed [P_W-1:0] z;
    logic                  flipped;
  } prod_t;

  // Block-scaled product as it travels down the normaliser.
  typedef struct packed {
    logic signed [COMP_W-1:0] w;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic                     flipped;
    logic                     zero;
  } norm_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/core/qmsn_front.sv @@
// Front end: accepts quaternion pairs, forms the Hamilton product and applies the flip.
module qmsn_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qmsn_pkg::COMP_W-1:0] a_w,
  input  logic signed [qmsn_pkg::COMP_W-1:0] a_x,
  input  logic signed [qmsn_pkg::COMP_W-1:0] a_y,
  input  logic signed [qmsn_pkg::COMP_W-1:0] a_z,
  input  logic signed [qmsn_pkg::COMP_W-1:0] b_w,
  input  logic signed [qmsn_pkg::COMP_W-1:0] b_x,
  input  logic signed [qmsn_pkg::COMP_W-1:0] b_y,
  input  logic signed [qmsn_pkg::COMP_W-1:0] b_z,
  input  qmsn_pkg::fifo_stat_t               q_stat,
  output logic                               push,
  output qmsn_pkg::prod_t                    push_data
);

  logic signed [qmsn_pkg::COMP_W-1:0] av [4];
  logic signed [qmsn_pkg::COMP_W-1:0] bv [4];
  logic signed [2*qmsn_pkg::COMP_W-1:0] full_prod [16];
  logic signed [qmsn_pkg::TERM_W-1:0] term_nxt [16];
  logic signed [qmsn_pkg::TERM_W-1:0] term_r [16];
  logic signed [qmsn_pkg::P_W-1:0] e [16];
  logic v1_r, v2_r, v3_r;
  logic en;
  qmsn_pkg::prod_t sum_nxt, sum_r, flip_nxt, flip_r;

  assign av[0] = a_w; assign av[1] = a_x; assign av[2] = a_y; assign av[3] = a_z;
  assign bv[0] = b_w; assign bv[1] = b_x; assign bv[2] = b_y; assign bv[3] = b_z;

  // The whole front end holds while its last stage is valid and the queue is full.
  assign en       = !(v3_r && q_stat.full);
  assign in_ready = en;
  assign push     = en && v3_r;
  assign push_data = flip_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        full_prod[i*4+j] = av[i] * bv[j];
        term_nxt[i*4+j]  = qmsn_pkg::TERM_W'(full_prod[i*4+j] >>> 29);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      e[i] = qmsn_pkg::P_W'(term_r[i]);
    end
    // Index is 4 * (first component) + (second component), w x y z order.
    sum_nxt.w = -e[5] - e[10] - e[15] + e[0];
    sum_nxt.x =  e[4] + e[11] - e[14] + e[1];
    sum_nxt.y = -e[7] + e[8]  + e[13] + e[2];
    sum_nxt.z =  e[6] - e[9]  + e[12] + e[3];
    sum_nxt.flipped = 1'b0;
  end

  always_comb begin
    flip_nxt = sum_r;
    if (sum_r.w < 0) begin
      flip_nxt.w = -sum_r.w;
      flip_nxt.x = -sum_r.x;
      flip_nxt.y = -sum_r.y;
      flip_nxt.z = -sum_r.z;
      flip_nxt.flipped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      term_r <= term_nxt;
      sum_r  <= sum_nxt;
      flip_r <= flip_nxt;
    end
  end

endmodule

@@ rtl/core/qmsn_fifo.sv @@
// Short queue that decouples the product front end from the normaliser.
module qmsn_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  qmsn_pkg::prod_t      push_data,
  input  logic                 pop,
  output qmsn_pkg::prod_t      pop_data,
  output qmsn_pkg::fifo_stat_t stat
);

  qmsn_pkg::prod_t mem [qmsn_pkg::FIFO_DEPTH];
  logic [qmsn_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [qmsn_pkg::FIFO_CW-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == qmsn_pkg::FIFO_CW'(qmsn_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/core/qmsn_back.sv @@
// Normaliser: block scaling, squared norm, pipelined square root and reciprocal, output scaling.
module qmsn_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  qmsn_pkg::fifo_stat_t               q_stat,
  input  qmsn_pkg::prod_t                    pop_data,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qmsn_pkg::COMP_W-1:0] prod_w,
  output logic signed [qmsn_pkg::COMP_W-1:0] prod_x,
  output logic signed [qmsn_pkg::COMP_W-1:0] prod_y,
  output logic signed [qmsn_pkg::COMP_W-1:0] prod_z,
  output logic                               was_flipped,
  output logic                               zero_norm
);

  localparam int NS = qmsn_pkg::SQRT_STAGES;
  localparam int ND = qmsn_pkg::DIV_STAGES;

  logic en;

  // Magnitude OR: its bit length equals that of the largest magnitude.
  logic                        b1_v_r;
  qmsn_pkg::prod_t             b1_p_r;
  logic [qmsn_pkg::MAG_W-1:0]  b1_or_r, or_nxt;

  logic                        b2_v_r;
  qmsn_pkg::prod_t             b2_p_r;
  logic [qmsn_pkg::LEN_W-1:0]  b2_len_r, len_nxt;
  logic                        b2_zero_r;

  logic                        b3_v_r;
  qmsn_pkg::norm_t             b3_c_r, c3_nxt;

  logic                        b4_v_r;
  qmsn_pkg::norm_t             b4_c_r;
  logic [qmsn_pkg::SQ_W-1:0]   b4_sq_r [4];
  logic signed [2*qmsn_pkg::COMP_W-1:0] sq_full [4];

  logic                        sq_v [0:NS];
  qmsn_pkg::norm_t             sq_c [0:NS];
  logic [qmsn_pkg::N_W-1:0]    sq_n [0:NS];
  logic [qmsn_pkg::N_W-1:0]    sq_res [0:NS];

  logic                        dv_v [0:ND];
  qmsn_pkg::norm_t             dv_c [0:ND];
  logic [qmsn_pkg::REM_W-1:0]  dv_rem [0:ND];
  logic [qmsn_pkg::R_W-1:0]    dv_qt [0:ND];
  logic [qmsn_pkg::S_W-1:0]    s_val;

  logic                        m_v_r;
  qmsn_pkg::norm_t             m_c_r;
  logic signed [qmsn_pkg::MUL_W-1:0] m_r [4];
  logic signed [qmsn_pkg::COMP_W-1:0] cq [4];

  logic signed [qmsn_pkg::COMP_W-1:0] o_nxt [4];
  logic out_valid_r;
  logic signed [qmsn_pkg::COMP_W-1:0] o_r [4];
  logic o_fl_r, o_zero_r;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_stat.empty;

  function automatic logic [qmsn_pkg::MAG_W-1:0] mag_of(input logic signed [qmsn_pkg::P_W-1:0] v);
    logic signed [qmsn_pkg::P_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[qmsn_pkg::MAG_W-1:0];
  endfunction

  assign or_nxt = mag_of(pop_data.w) | mag_of(pop_data.x) | mag_of(pop_data.y)
                | mag_of(pop_data.z);

  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < qmsn_pkg::MAG_W; i++) begin
      if (b1_or_r[i]) begin
        len_nxt = qmsn_pkg::LEN_W'(i + 1);
      end
    end
  end

  // Scale so that the largest magnitude lands in [2^29, 2^30].
  function automatic logic signed [qmsn_pkg::COMP_W-1:0] scale(
    input logic signed [qmsn_pkg::P_W-1:0] v, input logic [qmsn_pkg::LEN_W-1:0] len);
    logic signed [qmsn_pkg::P_W-1:0] t;
    if (len > qmsn_pkg::LEN_W'(30)) begin
      t = v >>> (len - qmsn_pkg::LEN_W'(30));
    end else begin
      t = v <<< (qmsn_pkg::LEN_W'(30) - len);
    end
    return t[qmsn_pkg::COMP_W-1:0];
  endfunction

  always_comb begin
    c3_nxt.w       = scale(b2_p_r.w, b2_len_r);
    c3_nxt.x       = scale(b2_p_r.x, b2_len_r);
    c3_nxt.y       = scale(b2_p_r.y, b2_len_r);
    c3_nxt.z       = scale(b2_p_r.z, b2_len_r);
    c3_nxt.flipped = b2_p_r.flipped;
    c3_nxt.zero    = b2_zero_r;
  end

  assign cq[0] = b3_c_r.w;
  assign cq[1] = b3_c_r.x;
  assign cq[2] = b3_c_r.y;
  assign cq[3] = b3_c_r.z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_full[i] = cq[i] * cq[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (en) begin
      b1_v_r    <= pop;
      b1_p_r    <= pop_data;
      b1_or_r   <= or_nxt;
      b2_v_r    <= b1_v_r;
      b2_p_r    <= b1_p_r;
      b2_len_r  <= len_nxt;
      b2_zero_r <= (b1_or_r == '0);
      b3_v_r    <= b2_v_r;
      b3_c_r    <= c3_nxt;
      b4_v_r    <= b3_v_r;
      b4_c_r    <= b3_c_r;
      for (int i = 0; i < 4; i++) begin
        b4_sq_r[i] <= sq_full[i][qmsn_pkg::SQ_W-1:0];
      end
      sq_v[0]   <= b4_v_r;
      sq_c[0]   <= b4_c_r;
      sq_n[0]   <= qmsn_pkg::N_W'(b4_sq_r[0]) + qmsn_pkg::N_W'(b4_sq_r[1])
                 + qmsn_pkg::N_W'(b4_sq_r[2]) + qmsn_pkg::N_W'(b4_sq_r[3]);
      sq_res[0] <= '0;
    end
  end

  // One result bit of the integer square root per stage.
  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    localparam logic [qmsn_pkg::N_W-1:0] BIT = qmsn_pkg::N_W'(1) << (62 - 2*g);
    logic [qmsn_pkg::N_W-1:0] trial;
    assign trial = sq_res[g] + BIT;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v[g+1] <= 1'b0;
      end else if (en) begin
        sq_v[g+1] <= sq_v[g];
        sq_c[g+1] <= sq_c[g];
        if (sq_n[g] >= trial) begin
          sq_n[g+1]   <= sq_n[g] - trial;
          sq_res[g+1] <= (sq_res[g] >> 1) + BIT;
        end else begin
          sq_n[g+1]   <= sq_n[g];
          sq_res[g+1] <= sq_res[g] >> 1;
        end
      end
    end
  end

  assign s_val     = sq_res[NS][qmsn_pkg::S_W-1:0];
  assign dv_v[0]   = sq_v[NS];
  assign dv_c[0]   = sq_c[NS];
  // Quotient bits above bit 33 are always zero, leaving 2^28 as the partial remainder.
  assign dv_rem[0] = qmsn_pkg::REM_W'(1) << 28;
  assign dv_qt[0]  = '0;

  // One quotient bit of floor(2^62 / s) per stage.
  for (genvar g = 0; g < ND; g++) begin : g_div
    logic [qmsn_pkg::REM_W-1:0] r2;
    logic ge;
    logic [qmsn_pkg::S_W-1:0] s_val_d;
    assign r2 = {dv_rem[g][qmsn_pkg::REM_W-2:0], 1'b0};
    assign ge = (r2 >= {1'b0, s_val_d});
    if (g == 0) begin : g_s0
      assign s_val_d = s_val;
    end else begin : g_sn
      logic [qmsn_pkg::S_W-1:0] s_r;
      always_ff @(posedge clk) begin
        if (en) begin
          s_r <= g_div[g-1].s_val_d;
        end
      end
      assign s_val_d = s_r;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[g+1] <= 1'b0;
      end else if (en) begin
        dv_v[g+1]   <= dv_v[g];
        dv_c[g+1]   <= dv_c[g];
        dv_rem[g+1] <= ge ? (r2 - {1'b0, s_val_d}) : r2;
        dv_qt[g+1]  <= {dv_qt[g][qmsn_pkg::R_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= dv_v[ND];
      m_c_r <= dv_c[ND];
      m_r[0] <= dv_c[ND].w * $signed({1'b0, dv_qt[ND]});
      m_r[1] <= dv_c[ND].x * $signed({1'b0, dv_qt[ND]});
      m_r[2] <= dv_c[ND].y * $signed({1'b0, dv_qt[ND]});
      m_r[3] <= dv_c[ND].z * $signed({1'b0, dv_qt[ND]});
    end
  end

  // Round half up, then clamp to the 32-bit range; a zero-norm product gives all zeros.
  always_comb begin
    logic signed [qmsn_pkg::MUL_W-1:0] rnd;
    logic signed [qmsn_pkg::MUL_W-34:0] v;
    for (int i = 0; i < 4; i++) begin
      rnd = m_r[i] + (qmsn_pkg::MUL_W'(1) <<< 32);
      v   = rnd[qmsn_pkg::MUL_W-1:33];
      if (m_c_r.zero) begin
        o_nxt[i] = '0;
      end else if (v > (qmsn_pkg::MUL_W-33)'(32'sh7fffffff)) begin
        o_nxt[i] = 32'sh7fffffff;
      end else if (v < -(qmsn_pkg::MUL_W-33)'(35'sh080000000)) begin
        o_nxt[i] = 32'sh80000000;
      end else begin
        o_nxt[i] = v[qmsn_pkg::COMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_v_r;
      o_r         <= o_nxt;
      o_fl_r      <= m_c_r.flipped && !m_c_r.zero;
      o_zero_r    <= m_c_r.zero;
    end
  end

  assign out_valid   = out_valid_r;
  assign prod_w      = o_r[0];
  assign prod_x      = o_r[1];
  assign prod_y      = o_r[2];
  assign prod_z      = o_r[3];
  assign was_flipped = o_fl_r;
  assign zero_norm   = o_zero_r;

endmodule

@@ rtl/core/quaternion_multiply_shortest_normalize_top.sv @@
// Top level of the normalised shortest-path quaternion product.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | in_first_{w,x,y,z}, in_second_{w,x,y,z}
//  out     | out_valid / out_ready| out_prod_{w,x,y,z}, out_was_flipped, out_zero_norm
//
// One transaction is accepted per cycle unless a full queue stalls the front end; each one yields one result.
// The accepting edge loads the first of 3 product stages; the result is then written
// to the queue and passes through 73 normaliser stages before out_valid rises,
// a count set by the 32-stage square root and the 34-stage reciprocal divider.
// rst_n is synchronous and clears all valid flags and queue pointers.
// An output stall freezes the normaliser; the front end keeps going until its queue fills.
module quaternion_multiply_shortest_normalize_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qmsn_pkg::COMP_W-1:0] in_first_w,
  input  logic signed [qmsn_pkg::COMP_W-1:0] in_first_x,
  input  logic signed [qmsn_pkg::COMP_W-1:0] in_first_y,
  input  logic signed [qmsn_pkg::COMP_W-1:0] in_first_z,
  input  logic signed [qmsn_pkg::COMP_W-1:0] in_second_w,
  input  logic signed [qmsn_pkg::COMP_W-1:0] in_second_x,
  input  logic signed [qmsn_pkg::COMP_W-1:0] in_second_y,
  input  logic signed [qmsn_pkg::COMP_W-1:0] in_second_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qmsn_pkg::COMP_W-1:0] out_prod_w,
  output logic signed [qmsn_pkg::COMP_W-1:0] out_prod_x,
  output logic signed [qmsn_pkg::COMP_W-1:0] out_prod_y,
  output logic signed [qmsn_pkg::COMP_W-1:0] out_prod_z,
  output logic                               out_was_flipped,
  output logic                               out_zero_norm
);

  qmsn_pkg::fifo_stat_t q_stat;
  qmsn_pkg::prod_t      push_data, pop_data;
  logic                 push, pop;

  qmsn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_w       (in_first_w),
    .a_x       (in_first_x),
    .a_y       (in_first_y),
    .a_z       (in_first_z),
    .b_w       (in_second_w),
    .b_x       (in_second_x),
    .b_y       (in_second_y),
    .b_z       (in_second_z),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  qmsn_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  qmsn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prod_w      (out_prod_w),
    .prod_x      (out_prod_x),
    .prod_y      (out_prod_y),
    .prod_z      (out_prod_z),
    .was_flipped (out_was_flipped),
    .zero_norm   (out_zero_norm)
  );

endmodule

@@ rtl/core/qmsn_checker.sv @@
// Port-level checks for the quaternion normaliser, bound to the top level.
module qmsn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [qmsn_pkg::COMP_W-1:0] in_first_w,
  input logic signed [qmsn_pkg::COMP_W-1:0] in_first_x,
  input logic signed [qmsn_pkg::COMP_W-1:0] in_first_y,
  input logic signed [qmsn_pkg::COMP_W-1:0] in_first_z,
  input logic signed [qmsn_pkg::COMP_W-1:0] in_second_w,
  input logic signed [qmsn_pkg::COMP_W-1:0] in_second_x,
  input logic signed [qmsn_pkg::COMP_W-1:0] in_second_y,
  input logic signed [qmsn_pkg::COMP_W-1:0] in_second_z,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [qmsn_pkg::COMP_W-1:0] out_prod_w,
  input logic signed [qmsn_pkg::COMP_W-1:0] out_prod_x,
  input logic signed [qmsn_pkg::COMP_W-1:0] out_prod_y,
  input logic signed [qmsn_pkg::COMP_W-1:0] out_prod_z,
  input logic                               out_was_flipped,
  input logic                               out_zero_norm
);

  // A zero product reports all-zero components and no flip.
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |-> out_prod_w == 0 && out_prod_x == 0 &&
      out_prod_y == 0 && out_prod_z == 0 && !out_was_flipped)
    else $error("zero-norm result is not clean");

  // After the flip the scalar part is never negative.
  a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_prod_w[qmsn_pkg::COMP_W-1])
    else $error("negative scalar part");

  // A unit-length result never exceeds one in magnitude; only the x component is checked.
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_prod_x <= 32'sh20000000 && out_prod_x >= -32'sh20000000))
    else $error("x component out of unit range");

  // A stalled result holds: out_valid stays high and the w and z components are stable.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prod_w) && $stable(out_prod_z))
    else $error("result changed while stalled");

endmodule

bind quaternion_multiply_shortest_normalize_top qmsn_checker u_qmsn_checker (.*);
